### src/ats_pkg.sv
// Shared types and constants for the adaptive threshold step counter.
`default_nettype none

package ats_pkg;

    localparam int unsigned WLEN_WIDTH     = 6;
    localparam int unsigned CALW_WIDTH     = 4;
    localparam int unsigned CFG_IDX_WIDTH  = 1;
    localparam int unsigned CFG_DATA_WIDTH = 6;

    localparam logic [WLEN_WIDTH-1:0] WLEN_RESET = 6'd20;
    localparam logic [CALW_WIDTH-1:0] CALW_RESET = 4'd5;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_WINDOW_LENGTH       = 1'b0,
        CFG_CALIBRATION_WINDOWS = 1'b1
    } t_cfg_reg;

endpackage

`default_nettype wire

### src/ats_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
`default_nettype none

interface ats_sample_if #(
    parameter int unsigned SAMPLE_WIDTH = 13
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] z_sample;

    modport source (output valid, output z_sample, input ready);
    modport sink   (input valid, input z_sample, output ready);
endinterface

interface ats_result_if #(
    parameter int unsigned SAMPLE_WIDTH = 13,
    parameter int unsigned COUNT_WIDTH  = 24
);
    logic                           valid;
    logic                           ready;
    logic        [COUNT_WIDTH-1:0]  step_count;
    logic                           step_detected;
    logic signed [SAMPLE_WIDTH-1:0] current_threshold;
    logic                           calibrating;

    modport source (output valid, output step_count, output step_detected,
                    output current_threshold, output calibrating, input ready);
    modport sink   (input valid, input step_count, input step_detected,
                    input current_threshold, input calibrating, output ready);
endinterface

interface ats_cfg_if
    import ats_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_IDX_WIDTH-1:0]  index;
    logic [CFG_DATA_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/adaptive_threshold_step_counter.sv
// Top level of the adaptive threshold step counter (pedometer peak detection).
//
// Usage notes:
//  - i_sample carries one signed vertical acceleration sample per request.
//  - o_result returns exactly one result per sample: the saturating step count,
//    a step flag, the threshold now in force and a calibrating flag.
//  - i_cfg writes register 0 (window length, 0 acts as 1) and register 1
//    (calibration windows). Always ready; write only while the block is idle.
//  - The sample is evaluated against the stored state in the cycle it is
//    accepted and the result register loads on that edge.
//  - Throughput: one sample per cycle, set by the single result register;
//    a new request is taken whenever that register is empty or being drained.
//  - Receiver stall: the result holds in its register, i_sample.ready drops
//    and the running state holds until the result is taken.
//  - Reset (synchronous, active low): threshold 0, latch clear, count 0,
//    extremes at the full range, window and calibration counters at 0,
//    registers back to window length 20 and 5 calibration windows.
//  - Steps seen during calibration are counted, then the count and latch are
//    cleared on the window end that finishes calibration.
`default_nettype none

module adaptive_threshold_step_counter
    import ats_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 13,
    parameter int unsigned COUNT_WIDTH  = 24
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ats_sample_if.sink     i_sample,
    ats_result_if.source   o_result,
    ats_cfg_if.sink        i_cfg
);

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    // configuration registers
    logic [WLEN_WIDTH-1:0] r_wlen;
    logic [CALW_WIDTH-1:0] r_calw;

    // running state
    logic [WLEN_WIDTH-1:0]          r_pos,   n_pos;
    logic signed [SAMPLE_WIDTH-1:0] r_max,   n_max;
    logic signed [SAMPLE_WIDTH-1:0] r_min,   n_min;
    logic signed [SAMPLE_WIDTH-1:0] r_thr,   n_thr;
    logic                           r_latch, n_latch;
    logic [COUNT_WIDTH-1:0]         r_cnt,   n_cnt;
    logic [CALW_WIDTH-1:0]          r_done,  n_done;

    // result register
    logic                           r_out_valid;
    logic                           r_det,   n_det;
    logic                           r_cal,   n_cal;

    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] z;
    logic                           rise, fall;
    logic signed [SAMPLE_WIDTH-1:0] max_a, min_a;
    logic signed [SAMPLE_WIDTH:0]   ext_sum;
    logic [WLEN_WIDTH-1:0]          len;
    logic [WLEN_WIDTH:0]            pos_inc;
    logic                           win_end;
    logic                           done_adv;
    logic [CALW_WIDTH-1:0]          done_inc;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = !r_out_valid || o_result.ready;
    assign accept         = i_sample.valid && i_sample.ready;
    assign z              = i_sample.z_sample;

    always_comb begin
        // step test against the threshold held before this sample
        rise = (z > r_thr) && !r_latch;
        fall = (z < r_thr) && r_latch;

        n_latch = r_latch;
        n_cnt   = r_cnt;
        if (rise) begin
            n_latch = 1'b1;
            if (r_cnt != {COUNT_WIDTH{1'b1}}) begin
                n_cnt = r_cnt + 1'b1;
            end
        end else if (fall) begin
            n_latch = 1'b0;
        end

        max_a = (z > r_max) ? z : r_max;
        min_a = (z < r_min) ? z : r_min;

        len     = (r_wlen == '0) ? WLEN_WIDTH'(1) : r_wlen;
        pos_inc = {1'b0, r_pos} + 1'b1;
        win_end = pos_inc >= {1'b0, len};

        // floored midpoint: arithmetic halving of the widened sum
        ext_sum  = {max_a[SAMPLE_WIDTH-1], max_a} + {min_a[SAMPLE_WIDTH-1], min_a};
        done_adv = r_done < r_calw;
        done_inc = r_done + 1'b1;

        n_thr  = r_thr;
        n_max  = max_a;
        n_min  = min_a;
        n_pos  = pos_inc[WLEN_WIDTH-1:0];
        n_done = r_done;
        if (win_end) begin
            n_thr = ext_sum[SAMPLE_WIDTH:1];
            n_max = SAMPLE_MIN;
            n_min = SAMPLE_MAX;
            n_pos = '0;
            if (done_adv) begin
                n_done = done_inc;
                if (done_inc == r_calw) begin
                    // calibration over: drop everything counted so far
                    n_cnt   = '0;
                    n_latch = 1'b0;
                end
            end
        end

        n_det = rise;
        n_cal = n_done < r_calw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RESET;
            r_calw <= CALW_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_WINDOW_LENGTH:       r_wlen <= i_cfg.data[WLEN_WIDTH-1:0];
                CFG_CALIBRATION_WINDOWS: r_calw <= i_cfg.data[CALW_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_max   <= SAMPLE_MIN;
            r_min   <= SAMPLE_MAX;
            r_thr   <= '0;
            r_latch <= 1'b0;
            r_cnt   <= '0;
            r_done  <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_max   <= n_max;
            r_min   <= n_min;
            r_thr   <= n_thr;
            r_latch <= n_latch;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_det <= n_det;
            r_cal <= n_cal;
        end
    end

    // count and threshold are read straight from the state registers,
    // which only move together with the result register
    assign o_result.valid             = r_out_valid;
    assign o_result.step_count        = r_cnt;
    assign o_result.step_detected     = r_det;
    assign o_result.current_threshold = r_thr;
    assign o_result.calibrating       = r_cal;

endmodule

`default_nettype wire

### dv/tb_adaptive_threshold_step_counter.sv
// Self-checking testbench for the step counter: directed and gait-like samples against a predictor.
`default_nettype none

module tb_adaptive_threshold_step_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import ats_pkg::*;

    localparam int SAMPLE_W    = 13;
    localparam int COUNT_W     = 24;
    // No request moves on any channel for this long: the block is hung.
    localparam int STALL_LIMIT = 2000;
    // Long receiver hold-off, enough to back the block up into its input.
    localparam int HOLD_CYCLES = 200;
    // Settling time after the last result.
    localparam int TAIL_CYCLES = 10;

    typedef logic signed [SAMPLE_W-1:0] accel_t;

    localparam accel_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam accel_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    typedef struct {
        logic [COUNT_W-1:0] step_count;
        logic               step_detected;
        accel_t             current_threshold;
        logic               calibrating;
    } step_tally_t;

    typedef struct {
        t_cfg_reg                  idx;
        logic [CFG_DATA_WIDTH-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    ats_sample_if #(.SAMPLE_WIDTH(SAMPLE_W))                        smp_if ();
    ats_result_if #(.SAMPLE_WIDTH(SAMPLE_W), .COUNT_WIDTH(COUNT_W)) res_if ();
    ats_cfg_if                                                      cfg_if ();

    adaptive_threshold_step_counter #(
        .SAMPLE_WIDTH(SAMPLE_W),
        .COUNT_WIDTH (COUNT_W)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sample(smp_if),
        .o_result(res_if),
        .i_cfg   (cfg_if)
    );

    // Stimulus queues, filled by the sequence below on falling edges only.
    accel_t       samples_to_send[$];
    reg_write_t   reg_writes_to_send[$];
    // Predicted results, oldest first.
    step_tally_t  awaited_tallies[$];

    int   mismatch_count = 0;
    int   send_wait      = 0;
    int   rcv_wait       = 0;
    int   hold_left      = 0;
    int   stall_cycles   = 0;
    bit   gaps_on        = 1'b0;
    bit   hold_request   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the counters.
    // ------------------------------------------------------------------
    logic [WLEN_WIDTH-1:0] win_len_reg;
    logic [CALW_WIDTH-1:0] cal_windows_reg;
    logic [WLEN_WIDTH-1:0] win_pos;
    accel_t                win_max;
    accel_t                win_min;
    accel_t                thr_level;
    logic                  rearm_latch;
    logic [COUNT_W-1:0]    steps;
    logic [CALW_WIDTH-1:0] windows_seen;

    // Advance the predictor by one sample and return the result it owes.
    // Order matters: step test against the old threshold, then the window
    // extremes, then the end-of-window update.
    function automatic step_tally_t tally_sample(input accel_t z);
        step_tally_t               r;
        int unsigned               len;
        logic signed [SAMPLE_W:0]  span;
        len             = (win_len_reg == '0) ? 1 : win_len_reg;
        r.step_detected = 1'b0;
        if (z > thr_level && !rearm_latch) begin
            r.step_detected = 1'b1;
            rearm_latch     = 1'b1;
            if (steps != '1) begin
                steps = steps + 1'b1;   // saturates at all ones
            end
        end else if (z < thr_level && rearm_latch) begin
            rearm_latch = 1'b0;         // equal to threshold leaves it set
        end
        if (z > win_max) win_max = z;
        if (z < win_min) win_min = z;
        if (win_pos + 1 >= len) begin
            // Floored midpoint: arithmetic shift of the widened sum.
            span      = win_max + win_min;
            thr_level = accel_t'(span >>> 1);
            win_max   = SAMPLE_MIN;
            win_min   = SAMPLE_MAX;
            win_pos   = '0;
            if (windows_seen < cal_windows_reg) begin
                windows_seen = windows_seen + 1'b1;
                // Calibration just finished: drop what was counted so far.
                if (windows_seen == cal_windows_reg) begin
                    steps       = '0;
                    rearm_latch = 1'b0;
                end
            end
        end else begin
            win_pos = win_pos + 1'b1;
        end
        r.step_count        = steps;
        r.current_threshold = thr_level;
        r.calibrating       = windows_seen < cal_windows_reg;
        return r;
    endfunction

    function automatic int draw_wait();
        return gaps_on ? int'($urandom_range(0, 10)) : 0;
    endfunction

    task automatic feed(input int v);
        samples_to_send.push_back(accel_t'(v));
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        reg_write_t w;
        w.idx  = idx;
        w.data = CFG_DATA_WIDTH'(val);
        reg_writes_to_send.push_back(w);
    endtask

    // Block is idle once nothing is queued, offered or owed.
    task automatic wait_quiet();
        do @(negedge clk);
        while (samples_to_send.size() != 0 || smp_if.valid ||
               reg_writes_to_send.size() != 0 || cfg_if.valid ||
               awaited_tallies.size() != 0);
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sample driver: one request per queued sample, with a drawn gap after
    // each. The prediction is taken at the edge the request is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            smp_if.valid <= 1'b0;
            send_wait    <= 0;
        end else begin
            if (smp_if.valid && smp_if.ready) begin
                awaited_tallies.push_back(tally_sample(smp_if.z_sample));
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (send_wait == 0 && samples_to_send.size() != 0) begin
                    smp_if.valid    <= 1'b1;
                    smp_if.z_sample <= samples_to_send.pop_front();
                    send_wait       <= draw_wait();
                end else begin
                    smp_if.valid <= 1'b0;
                    if (send_wait != 0) send_wait <= send_wait - 1;
                end
            end
        end
    end

    // Register write driver; the predictor's copy changes on acceptance.
    always @(posedge clk) begin : reg_write_driver
        reg_write_t w;
        if (!rst_n) begin
            cfg_if.valid <= 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_cfg_reg'(cfg_if.index))
                    CFG_WINDOW_LENGTH:       win_len_reg     = cfg_if.data[WLEN_WIDTH-1:0];
                    CFG_CALIBRATION_WINDOWS: cal_windows_reg = cfg_if.data[CALW_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (reg_writes_to_send.size() != 0) begin
                    w = reg_writes_to_send.pop_front();
                    cfg_if.valid <= 1'b1;
                    cfg_if.index <= w.idx;
                    cfg_if.data  <= w.data;
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver: checks each accepted result against the
    // oldest prediction, then draws a stall before taking the next one.
    // A hold-off request keeps ready low for a long stretch.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        step_tally_t want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            rcv_wait      = 0;
            hold_left     = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_tallies.size() == 0) begin
                    $error("unexpected result: step_count %0d", res_if.step_count);
                    mismatch_count++;
                end else begin
                    want = awaited_tallies.pop_front();
                    if (res_if.step_count !== want.step_count) begin
                        $error("step_count: expected %0d, actual %0d",
                               want.step_count, res_if.step_count);
                        mismatch_count++;
                    end
                    if (res_if.step_detected !== want.step_detected) begin
                        $error("step_detected: expected %0d, actual %0d",
                               want.step_detected, res_if.step_detected);
                        mismatch_count++;
                    end
                    if (res_if.current_threshold !== want.current_threshold) begin
                        $error("current_threshold: expected %0d, actual %0d",
                               want.current_threshold, res_if.current_threshold);
                        mismatch_count++;
                    end
                    if (res_if.calibrating !== want.calibrating) begin
                        $error("calibrating: expected %0d, actual %0d",
                               want.calibrating, res_if.calibrating);
                        mismatch_count++;
                    end
                end
                rcv_wait = draw_wait();
            end
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: any accepted request on any channel counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed corner cases, then randomised phases, each
    // under its own register settings and written only while idle.
    // ------------------------------------------------------------------
    initial begin
        int n_items;
        int offset;
        int amp;
        int period;
        int noise;
        int jitter;
        int ramp;
        int mode;
        int v;
        int wl;
        int cw;

        smp_if.valid    = 1'b0;
        smp_if.z_sample = '0;
        res_if.ready    = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;

        // Predictor reset state mirrors the block's.
        win_len_reg     = WLEN_RESET;
        cal_windows_reg = CALW_RESET;
        win_pos         = '0;
        win_max         = SAMPLE_MIN;
        win_min         = SAMPLE_MAX;
        thr_level       = '0;
        rearm_latch     = 1'b0;
        steps           = '0;
        windows_seen    = '0;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings, full-scale samples, a window left part-filled.
        feed(4095);
        feed(-4096);
        feed(0);
        wait_quiet();

        // Zero length acts as one, ending the part-filled window at once;
        // no calibration, so counting is live. Repeats sit on the threshold.
        write_reg(CFG_WINDOW_LENGTH, 0);
        write_reg(CFG_CALIBRATION_WINDOWS, 0);
        wait_quiet();
        feed(0);
        feed(0);
        feed(-1);
        feed(1);
        feed(4095);
        feed(4095);
        feed(-4096);
        feed(-4096);
        wait_quiet();

        // Length cut mid-window: the window closes on the next sample.
        write_reg(CFG_WINDOW_LENGTH, 10);
        wait_quiet();
        feed(100);
        feed(-100);
        feed(50);
        feed(-50);
        feed(7);
        wait_quiet();
        write_reg(CFG_WINDOW_LENGTH, 3);
        wait_quiet();
        feed(-3);
        wait_quiet();

        // Calibration resumes; a step lands on the sample that ends it.
        write_reg(CFG_WINDOW_LENGTH, 2);
        write_reg(CFG_CALIBRATION_WINDOWS, 1);
        wait_quiet();
        feed(-4096);
        feed(4095);
        wait_quiet();

        // Calibration setting dropped below the windows already seen.
        write_reg(CFG_CALIBRATION_WINDOWS, 0);
        wait_quiet();
        feed(-4096);
        feed(4095);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    wl = 1;
                    cw = 0;
                end
                1: begin
                    wl = 63;
                    cw = 15;
                end
                2: begin
                    wl = 0;
                    cw = $urandom_range(6, 12);
                end
                default: begin
                    wl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(1, 12);
                    cw = $urandom_range(0, 15);
                end
            endcase
            // Upper data bits are don't-care for the calibration register.
            write_reg(CFG_WINDOW_LENGTH, wl);
            write_reg(CFG_CALIBRATION_WINDOWS, cw | ($urandom_range(0, 3) << CALW_WIDTH));
            wait_quiet();

            gaps_on = (ph % 3) != 0;
            n_items = $urandom_range(40, 60);
            // Mostly a noisy triangle gait, sometimes plain noise.
            mode    = $urandom_range(0, 4);
            offset  = $urandom_range(0, 4000);
            offset  = offset - 2000;
            amp     = $urandom_range(20, 4095);
            period  = $urandom_range(4, 24);
            noise   = $urandom_range(0, amp / 8);
            for (int k = 0; k < n_items; k++) begin
                if (mode == 0 || $urandom_range(0, 15) == 0) begin
                    v = $urandom_range(0, 8191);
                    v = v - 4096;
                end else begin
                    ramp = k % period;
                    if (ramp > period / 2) ramp = period - ramp;
                    jitter = $urandom_range(0, 2 * noise);
                    v = offset - amp + (4 * amp * ramp) / period + jitter - noise;
                    if (v > 4095) v = 4095;
                    if (v < -4096) v = -4096;
                end
                feed(v);
            end
            // Back-pressure: receiver holds off while requests keep coming.
            if (ph == 3) hold_request = 1'b1;
            wait_quiet();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_tallies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/ats_pkg.sv
src/ats_if.sv
src/adaptive_threshold_step_counter.sv
dv/tb_adaptive_threshold_step_counter.sv
